### hw/rtl/plut_pkg.sv
// shared types, codes and constants of the piecewise linear lookup table
package plut_pkg;

    // default table depth and reset value of the entry count register
    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam logic [4:0] ENTRIES_RESET = 5'd16;

    // configuration port geometry
    localparam int PADDR_W = 3;
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    // serial divider: the quotient always fits in 16 bits
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // transaction function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // result kinds
    localparam logic [2:0] KIND_CLAMP_LOW  = 3'd0;
    localparam logic [2:0] KIND_CLAMP_HIGH = 3'd1;
    localparam logic [2:0] KIND_EXACT      = 3'd2;
    localparam logic [2:0] KIND_INTERP     = 3'd3;
    localparam logic [2:0] KIND_NO_SEGMENT = 3'd4;

    typedef struct packed {
        logic        func;
        logic [3:0]  entry_index;
        logic [15:0] speed;
        logic [15:0] duty_in;
    } in_item_t;

    typedef struct packed {
        logic [15:0] duty_out;
        logic [2:0]  match_kind;
    } out_item_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic [15:0] key;
        logic [15:0] value;
    } entry_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic        done;
        logic [15:0] quot;
        logic        rem_nz;
    } div_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/piecewise_linear_table_lookup.sv
// top level: piecewise linear speed to duty lookup table with its sequencer
//
// Input transactions on s_valid/s_ready carry in_item_t. func 0 writes key
// and duty into slot entry_index (slots at or beyond the table depth are
// dropped) and gives no result. func 1 looks up speed
// and gives one out_item_t on m_valid/m_ready.
// A lookup reads entry 0 and the last active entry from the table memory,
// one entry per cycle, then walks the segments one memory read per cycle.
// A clamp is decided once both entries have been read; a segment hit ends
// the walk, and an interpolation adds a multiply step and the serial divider.
// The block takes the next transaction in the cycle after a result is
// loaded into the output register, so a lookup can run while an earlier
// result waits; if the receiver still holds the earlier result when the
// next one is done, the sequencer waits. entries_in_use is written at APB
// offset 0 and is clamped to 2 .. TABLE_DEPTH on use.
// Reset clears control state and sets entries_in_use to 16; the table is
// not cleared and entries must be written before lookups use them.
module piecewise_linear_table_lookup import plut_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    state_t           state_reg, state_next;
    logic [4:0]       entries_reg;
    logic [15:0]      spd_reg, spd_next;
    logic [15:0]      v0_reg, v0_next;
    logic [15:0]      prev_key_reg, prev_key_next;
    logic [15:0]      prev_val_reg, prev_val_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic [15:0]      dy_reg, dy_next;
    logic [15:0]      dx_reg, dx_next;
    logic [15:0]      den_reg, den_next;
    logic             fall_reg, fall_next;
    logic [15:0]      res_duty_reg, res_duty_next;
    logic [2:0]       res_kind_reg, res_kind_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;

    logic             div_start;
    logic [31:0]      div_dividend;
    div_result_t      div_res;

    logic [31:0]      cnt_ext;
    logic [31:0]      last_ext;
    logic [IDX_W-1:0] last_idx;
    logic [31:0]      slot_ext;
    logic             s_fire;
    logic             out_free;
    logic             cfg_wr;
    logic [16:0]      step;

    // apb register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE);
    assign prdata = (paddr[PADDR_W-1:2] == REG_ENTRIES_IN_USE)
                    ? {27'd0, entries_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= ENTRIES_RESET;
        end else if (cfg_wr) begin
            entries_reg <= pwdata[4:0];
        end
    end

    // index of the last active entry
    always_comb begin
        cnt_ext = 32'(entries_reg);
        if (cnt_ext < 32'd2) begin
            last_ext = 32'd1;
        end else if (cnt_ext > 32'(TABLE_DEPTH)) begin
            last_ext = 32'(TABLE_DEPTH - 1);
        end else begin
            last_ext = cnt_ext - 32'd1;
        end
        last_idx = last_ext[IDX_W-1:0];
    end

    // handshake
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign slot_ext = 32'(s_data.entry_index);

    // table write from a write transaction
    assign mem_we          = s_fire && (s_data.func == FUNC_WRITE)
                             && (slot_ext < 32'(TABLE_DEPTH));
    assign mem_waddr       = slot_ext[IDX_W-1:0];
    assign mem_wdata.key   = s_data.speed;
    assign mem_wdata.value = s_data.duty_in;

    // multiply feeding the divider
    assign div_dividend = {16'd0, dy_reg} * {16'd0, dx_reg};
    assign div_start    = (state_reg == ST_MUL);

    // sequencer next state and datapath
    always_comb begin
        state_next    = state_reg;
        spd_next      = spd_reg;
        v0_next       = v0_reg;
        prev_key_next = prev_key_reg;
        prev_val_next = prev_val_reg;
        cur_idx_next  = cur_idx_reg;
        dy_next       = dy_reg;
        dx_next       = dx_reg;
        den_next      = den_reg;
        fall_next     = fall_reg;
        res_duty_next = res_duty_reg;
        res_kind_next = res_kind_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_raddr     = '0;
        step          = {1'b0, div_res.quot} + {16'd0, div_res.rem_nz};
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.func == FUNC_LOOKUP)) begin
                    spd_next   = s_data.speed;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST: begin
                // entry 0 arrives, fetch the last active entry
                v0_next       = mem_rdata.value;
                prev_key_next = mem_rdata.key;
                prev_val_next = mem_rdata.value;
                mem_raddr     = last_idx;
                state_next    = ST_LAST;
            end
            ST_LAST: begin
                if (spd_reg <= prev_key_reg) begin
                    res_duty_next = v0_reg;
                    res_kind_next = KIND_CLAMP_LOW;
                    state_next    = ST_DONE;
                end else if (spd_reg >= mem_rdata.key) begin
                    res_duty_next = mem_rdata.value;
                    res_kind_next = KIND_CLAMP_HIGH;
                    state_next    = ST_DONE;
                end else begin
                    mem_raddr    = IDX_W'(1);
                    cur_idx_next = IDX_W'(1);
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // segment from prev entry to the entry just read
                if (spd_reg == prev_key_reg) begin
                    res_duty_next = prev_val_reg;
                    res_kind_next = KIND_EXACT;
                    state_next    = ST_DONE;
                end else if (spd_reg >= prev_key_reg && spd_reg <= mem_rdata.key) begin
                    dx_next   = spd_reg - prev_key_reg;
                    den_next  = mem_rdata.key - prev_key_reg;
                    fall_next = mem_rdata.value < prev_val_reg;
                    dy_next   = (mem_rdata.value < prev_val_reg)
                                ? prev_val_reg - mem_rdata.value
                                : mem_rdata.value - prev_val_reg;
                    state_next = ST_MUL;
                end else if (cur_idx_reg < last_idx) begin
                    prev_key_next = mem_rdata.key;
                    prev_val_next = mem_rdata.value;
                    mem_raddr     = IDX_W'(32'(cur_idx_reg) + 32'd1);
                    cur_idx_next  = IDX_W'(32'(cur_idx_reg) + 32'd1);
                end else begin
                    res_duty_next = v0_reg;
                    res_kind_next = KIND_NO_SEGMENT;
                    state_next    = ST_DONE;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // falling segments round the step up so the floor holds
                if (div_res.done) begin
                    res_duty_next = fall_reg ? 16'(prev_val_reg - step[15:0])
                                             : 16'(prev_val_reg + div_res.quot);
                    res_kind_next = KIND_INTERP;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.duty_out   = res_duty_reg;
                    m_data_next.match_kind = res_kind_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        spd_reg      <= spd_next;
        v0_reg       <= v0_next;
        prev_key_reg <= prev_key_next;
        prev_val_reg <= prev_val_next;
        cur_idx_reg  <= cur_idx_next;
        dy_reg       <= dy_next;
        dx_reg       <= dx_next;
        den_reg      <= den_next;
        fall_reg     <= fall_next;
        res_duty_reg <= res_duty_next;
        res_kind_reg <= res_kind_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    plut_table_mem #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    plut_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .result   (div_res)
    );

    // a new result is loaded only when the sequencer finishes a lookup
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside of the finish state");

    // divider completes only while the sequencer waits for it
    a_div_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside of the divide state");

    // segment walk stays within the active entries
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cur_idx_reg <= last_idx))
        else $error("segment walk beyond the last active entry");

    // no table write while a lookup is in flight
    a_no_write_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("table written during a lookup");

endmodule

### hw/rtl/plut_table_mem.sv
// key and duty table memory, one write port and one registered read port
module plut_table_mem import plut_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int IDX_W       = $clog2(DEFAULT_TABLE_DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t entry_mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= entry_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/plut_divider.sv
// restoring serial divider, one quotient bit per cycle, 16-bit quotient
module plut_divider import plut_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output div_result_t result
);

    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          low_reg, low_next;
    logic [15:0]          den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [16:0]          shifted;
    logic [16:0]          diff;
    logic                 fits;

    // one trial subtraction
    always_comb begin
        shifted   = {rem_reg, low_reg[15]};
        diff      = shifted - {1'b0, den_reg};
        fits      = shifted >= {1'b0, den_reg};
        rem_next  = rem_reg;
        low_next  = low_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            // high half is below the divisor since the quotient fits 16 bits
            rem_next = dividend[31:16];
            low_next = dividend[15:0];
            den_next = divisor;
            cnt_next = DIV_CNT_W'(DIV_STEPS);
        end else if (cnt_reg != '0) begin
            rem_next = fits ? diff[15:0] : shifted[15:0];
            low_next = {low_reg[14:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        den_reg <= den_next;
    end

    assign result.done   = done_reg;
    assign result.quot   = low_reg;
    assign result.rem_nz = (rem_reg != '0);

endmodule
